// ----- design/bsa_pkg.sv -----
// Shared constants and types for the buffer slot allocator.
package bsa_pkg;

    localparam int ADDR_W              = 32;
    localparam int SLOT_COUNT_DEF      = 16;
    localparam int SLOT_SIZE_LOG2_DEF  = 11;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_FREE    = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic set;
        logic clr;
    } map_op_t;

endpackage

// ----- design/bsa_free_map.sv -----
// Free slot map: one bit per slot, all set at reset, single bit read/set/clear.
module bsa_free_map
    import bsa_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int IDX_W      = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  map_op_t          op,
    input  logic [IDX_W-1:0] idx,
    output logic             map_bit
);

    logic [SLOT_COUNT-1:0] map_reg;
    logic [SLOT_COUNT-1:0] map_next;

    assign map_bit = map_reg[idx];

    always_comb
    begin
        map_next = map_reg;
        if (op.set)
        begin
            map_next[idx] = 1'b1;
        end
        else if (op.clr)
        begin
            map_next[idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg <= '1;
        end
        else
        begin
            map_reg <= map_next;
        end
    end

endmodule

// ----- design/buffer_slot_allocator.sv -----
// Buffer slot allocator top level: command sequencer, slot scan and result register.
//
// Usage:
//   s_tvalid/s_tready/s_tuser/s_tdata carry one command word. s_tuser is the
//   command (0 allocate, 1 free), s_tdata the byte address to free.
//   m_tvalid/m_tready/m_tuser/m_tdata return one result word per allocate:
//   m_tuser is the status (0 OK, 1 FAIL), m_tdata the granted slot address
//   (zero on FAIL). A free returns nothing.
//   cfg_valid/cfg_ready/cfg_data write pool_base; write it only while idle.
// Sequence:
//   A free is accepted, then takes one subtract, shift and compare.
//   An allocate is accepted, then the scan counter visits one slot per cycle,
//   while the output register has room, from slot 0 until it finds a free bit;
//   then one adder forms pool_base + index * slot size into the result register.
//   s_tready is high only while the sequencer is idle.
// Reset: every slot is free, pool_base is 0, no result is pending.
// Stall: a result waits in the output register while m_tready is low; a
//   new command is still taken, but its scan holds in place until the
//   register drains.
module buffer_slot_allocator
    import bsa_pkg::*;
#(
    parameter int SLOT_COUNT     = SLOT_COUNT_DEF,
    parameter int SLOT_SIZE_LOG2 = SLOT_SIZE_LOG2_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [0:0]        s_tuser,   // [0] command
    input  logic [ADDR_W-1:0] s_tdata,   // [31:0] free_address
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [0:0]        m_tuser,   // [0] status
    output logic [ADDR_W-1:0] m_tdata,   // [31:0] slot_address
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ADDR_W-1:0] cfg_data
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FREE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_status_reg, out_status_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;

    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] free_slot;
    logic              free_hit;
    logic [IDX_W-1:0]  map_idx;
    logic              map_bit;
    logic              out_room;
    logic              last_slot;
    map_op_t           map_op;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_status_reg;
    assign m_tdata   = out_addr_reg;

    assign offset    = addr_reg - base_reg;
    assign free_slot = offset >> SLOT_SIZE_LOG2;
    assign free_hit  = (free_slot < ADDR_W'(SLOT_COUNT));
    assign map_idx   = (state_reg == ST_FREE) ? free_slot[IDX_W-1:0] : idx_reg;
    assign out_room  = !out_valid_reg || m_tready;
    assign last_slot = (idx_reg == IDX_W'(SLOT_COUNT - 1));

    bsa_free_map #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (map_op),
        .idx     (map_idx),
        .map_bit (map_bit)
    );

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        addr_next       = addr_reg;
        base_next       = base_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        map_op          = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            base_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    addr_next = s_tdata;
                    idx_next  = '0;
                    state_next = (s_tuser[0] == CMD_FREE) ? ST_FREE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (out_room)
                begin
                    if (map_bit)
                    begin
                        map_op.clr      = 1'b1;
                        out_valid_next  = 1'b1;
                        out_status_next = STATUS_OK;
                        out_addr_next   = base_reg
                                        + (ADDR_W'(idx_reg) << SLOT_SIZE_LOG2);
                        state_next      = ST_IDLE;
                    end
                    else if (last_slot)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = STATUS_FAIL;
                        out_addr_next   = '0;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_FREE:
            begin
                map_op.set = free_hit;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            base_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            base_reg      <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        addr_reg       <= addr_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
    end

endmodule
